// ===== rtl/core/direct_mapped_writeback_cache_tags_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag unit
// Each macro checks a property on the rising clock edge, outside reset.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_TAGS_UNIT_MACROS_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_TAGS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMWBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMWBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dmwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Types and constants shared by the cache tag unit and its channels.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

    localparam int ADDR_BITS           = 16;
    localparam int DEF_MAX_LINES       = 256;
    localparam int MAX_BLOCK_WORDS     = 32;
    localparam int CNT_W               = 32;

    // Smallest split takes one offset bit and one index bit.
    localparam int TAG_W               = ADDR_BITS - 2;

    // Largest usable words_log2 value.
    localparam int WORD_BITS           = $clog2(MAX_BLOCK_WORDS + 1) - 1;

    localparam int CFG_IDX_W           = 1;
    localparam int CFG_DATA_W          = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS_LOG2  = 1'b1;

    localparam logic [3:0] RST_BLOCKS_LOG2 = 4'd8;
    localparam logic [2:0] RST_WORDS_LOG2  = 3'd2;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [ADDR_BITS-1:0] word_address;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic             wrote_back;
        logic [CNT_W-1:0] cpu_reads;
        logic [CNT_W-1:0] cpu_writes;
        logic [CNT_W-1:0] mem_words_read;
        logic [CNT_W-1:0] mem_words_written;
        logic [CNT_W-1:0] read_hits;
        logic [CNT_W-1:0] read_misses;
        logic [CNT_W-1:0] write_hits;
        logic [CNT_W-1:0] write_misses;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_beat;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } t_line;

endpackage

// ===== rtl/core/dmwbc_chan_if.sv =====
// ----------------------------------------------------------------------------
// dmwbc_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface dmwbc_chan_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/direct_mapped_writeback_cache_tags_unit.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_tags_unit
// Tag and state controller of a direct-mapped, write-back, write-allocate
// cache, with saturating access and traffic counters.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                 Beat
//   i_cfg    in   index, data                             register write
//   i_req    in   action, word_address                    one CPU access
//   o_rsp    out  hit, wrote_back, eight counters         one access result
//
// An access reads the tag memory in the cycle the beat is taken; the line
// is checked, updated and written back in state S_LOOK, which follows it.
// After reset a clearing pass zeroes all 2**floor(log2(MAX_LINES)) lines
// (256 by default) of the tag memory; no access is taken during it.
// A result waiting on o_rsp holds the update of the next access back until it
// is taken. Configuration beats are taken in every cycle.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_tags_unit #(
    parameter int MAX_LINES = dmwbc_pkg::DEF_MAX_LINES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dmwbc_chan_if.sink        i_cfg,
    dmwbc_chan_if.sink        i_req,
    dmwbc_chan_if.source      o_rsp
);

    import dmwbc_pkg::*;

    `include "direct_mapped_writeback_cache_tags_unit_macros.svh"

    localparam int         LINE_BITS = $clog2(MAX_LINES + 1) - 1;
    localparam int         LINES     = 1 << LINE_BITS;
    localparam logic [3:0] LINE_TOP  = 4'(LINE_BITS);
    localparam logic [3:0] WORD_TOP  = 4'(WORD_BITS);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [LINE_BITS-1:0] r_clr_idx;

    logic [3:0]           r_blocks_log2;
    logic [2:0]           r_words_log2;

    t_line                r_line_mem [LINES];
    t_line                r_rdata;

    logic                 r_action;
    logic [LINE_BITS-1:0] r_idx;
    logic [TAG_W-1:0]     r_tag;
    logic [3:0]           r_wb;

    logic                 r_out_valid;
    logic                 r_hit;
    logic                 r_wrote_back;
    logic [CNT_W-1:0]     r_cpu_reads;
    logic [CNT_W-1:0]     r_cpu_writes;
    logic [CNT_W-1:0]     r_mem_words_read;
    logic [CNT_W-1:0]     r_mem_words_written;
    logic [CNT_W-1:0]     r_read_hits;
    logic [CNT_W-1:0]     r_read_misses;
    logic [CNT_W-1:0]     r_write_hits;
    logic [CNT_W-1:0]     r_write_misses;

    logic                 req_acc;
    logic                 look_done;
    logic [3:0]           ib;
    logic [3:0]           wb;
    logic [ADDR_BITS-1:0] idx_full;
    logic [ADDR_BITS-1:0] tag_full;
    logic [4:0]           tag_sh;
    logic                 hit;
    logic                 victim;
    logic [CNT_W-1:0]     block_words;
    logic                 mem_we;
    logic [LINE_BITS-1:0] mem_waddr;
    t_line                mem_wdata;

    function automatic logic [CNT_W-1:0] sat_add(
        input logic [CNT_W-1:0] a,
        input logic [CNT_W-1:0] n
    );
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, n};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && (r_state == S_IDLE);
    assign look_done   = (r_state == S_LOOK) && (!r_out_valid || o_rsp.ready);

    // Out-of-range sizes are pulled into the usable range at use.
    always_comb begin
        if (r_blocks_log2 == 4'd0) begin
            ib = 4'd1;
        end else if (r_blocks_log2 > LINE_TOP) begin
            ib = LINE_TOP;
        end else begin
            ib = r_blocks_log2;
        end
        if (r_words_log2 == 3'd0) begin
            wb = 4'd1;
        end else if ({1'b0, r_words_log2} > WORD_TOP) begin
            wb = WORD_TOP;
        end else begin
            wb = {1'b0, r_words_log2};
        end
    end

    assign idx_full = (i_req.payload.word_address >> wb)
                      & ~({ADDR_BITS{1'b1}} << ib);
    assign tag_sh   = {1'b0, wb} + {1'b0, ib};
    assign tag_full = i_req.payload.word_address >> tag_sh;

    assign hit         = r_rdata.valid && (r_rdata.tag == r_tag);
    assign victim      = r_rdata.valid && r_rdata.dirty && !hit;
    assign block_words = CNT_W'(1) << r_wb;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rdata;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = '0;
        end else if (look_done) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b1;
            if (hit) begin
                mem_wdata.dirty = r_rdata.dirty || (r_action == ACT_WRITE);
                mem_wdata.tag   = r_rdata.tag;
            end else begin
                mem_wdata.dirty = (r_action == ACT_WRITE);
                mem_wdata.tag   = r_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[mem_waddr] <= mem_wdata;
        end
        if (req_acc) begin
            r_rdata <= r_line_mem[idx_full[LINE_BITS-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == {LINE_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (look_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_blocks_log2 <= RST_BLOCKS_LOG2;
            r_words_log2  <= RST_WORDS_LOG2;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.payload.index)
                    REG_BLOCKS_LOG2: r_blocks_log2 <= i_cfg.payload.data[3:0];
                    REG_WORDS_LOG2:  r_words_log2  <= i_cfg.payload.data[2:0];
                    default: ;
                endcase
            end
        end
    end

    // Split of the accepted address, held for the update cycle.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_action <= i_req.payload.action;
            r_idx    <= idx_full[LINE_BITS-1:0];
            r_tag    <= tag_full[TAG_W-1:0];
            r_wb     <= wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid         <= 1'b0;
            r_hit               <= 1'b0;
            r_wrote_back        <= 1'b0;
            r_cpu_reads         <= '0;
            r_cpu_writes        <= '0;
            r_mem_words_read    <= '0;
            r_mem_words_written <= '0;
            r_read_hits         <= '0;
            r_read_misses       <= '0;
            r_write_hits        <= '0;
            r_write_misses      <= '0;
        end else if (look_done) begin
            r_out_valid  <= 1'b1;
            r_hit        <= hit;
            r_wrote_back <= victim;
            if (r_action == ACT_WRITE) begin
                r_cpu_writes <= sat_add(r_cpu_writes, CNT_W'(1));
                if (hit) begin
                    r_write_hits <= sat_add(r_write_hits, CNT_W'(1));
                end else begin
                    r_write_misses <= sat_add(r_write_misses, CNT_W'(1));
                end
            end else begin
                r_cpu_reads <= sat_add(r_cpu_reads, CNT_W'(1));
                if (hit) begin
                    r_read_hits <= sat_add(r_read_hits, CNT_W'(1));
                end else begin
                    r_read_misses <= sat_add(r_read_misses, CNT_W'(1));
                end
            end
            if (!hit) begin
                r_mem_words_read <= sat_add(r_mem_words_read, block_words);
            end
            if (victim) begin
                r_mem_words_written <= sat_add(r_mem_words_written, block_words);
            end
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The counters only move when a result is loaded, so they serve directly
    // as the payload of the waiting result.
    always_comb begin
        o_rsp.valid                     = r_out_valid;
        o_rsp.payload.hit               = r_hit;
        o_rsp.payload.wrote_back        = r_wrote_back;
        o_rsp.payload.cpu_reads         = r_cpu_reads;
        o_rsp.payload.cpu_writes        = r_cpu_writes;
        o_rsp.payload.mem_words_read    = r_mem_words_read;
        o_rsp.payload.mem_words_written = r_mem_words_written;
        o_rsp.payload.read_hits         = r_read_hits;
        o_rsp.payload.read_misses       = r_read_misses;
        o_rsp.payload.write_hits        = r_write_hits;
        o_rsp.payload.write_misses      = r_write_misses;
    end

    `DMWBC_ASSERT_NOW(a_hit_no_writeback, r_out_valid, !(r_hit && r_wrote_back), "hit with write-back")
    `DMWBC_ASSERT_NEXT(a_accept_to_look, req_acc, r_state == S_LOOK, "accepted access not looked up")
    `DMWBC_ASSERT_NEXT(a_done_loads_result, look_done, r_out_valid, "finished access gave no result")
    `DMWBC_ASSERT_NEXT(a_stall_holds_counts, r_out_valid && !o_rsp.ready, $stable(r_cpu_reads) && $stable(r_cpu_writes) && $stable(r_mem_words_read), "counters moved under a stalled result")

endmodule

// ===== tb/direct_mapped_writeback_cache_tags_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag unit access checker
// Watches the register, access and result channels. It keeps its own copy of
// the split registers, the line store and the eight counters, works out the
// result of every accepted access, and compares each result beat field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_tags_unit_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  dmwbc_pkg::t_cfg_beat  i_cfg_beat,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  dmwbc_pkg::t_req       i_req_beat,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  dmwbc_pkg::t_rsp       i_rsp_beat,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    import dmwbc_pkg::*;

    localparam int               LINE_BITS   = $clog2(DEF_MAX_LINES);
    localparam logic [CNT_W-1:0] CNT_MAX     = '1;
    localparam int               PRINT_LIMIT = 200;

    logic [3:0]       blocks_log2_q;
    logic [2:0]       words_log2_q;
    logic             line_valid [DEF_MAX_LINES];
    logic             line_dirty [DEF_MAX_LINES];
    logic [TAG_W-1:0] line_tag   [DEF_MAX_LINES];
    t_rsp             tallies;
    t_rsp             outcomes_due [$];
    int               mismatches = 0;
    int               due_count  = 0;

    assign o_fail_count  = mismatches;
    assign o_outstanding = due_count;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] base,
                                                 input int unsigned amount);
        logic [CNT_W:0] sum;
        sum = {1'b0, base} + amount;
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    // Looks up one access, updates the line store and counters, and returns
    // the result beat the unit should produce for it.
    task automatic predict_access(input t_req acc, output t_rsp res);
        int               ib;
        int               wb;
        int               idx;
        int unsigned      block_words;
        logic [TAG_W-1:0] tag;
        logic             hit;
        logic             is_write;
        ib = int'(blocks_log2_q);
        if (ib < 1) ib = 1;
        else if (ib > LINE_BITS) ib = LINE_BITS;
        wb = int'(words_log2_q);
        if (wb < 1) wb = 1;
        else if (wb > WORD_BITS) wb = WORD_BITS;
        block_words = 1 << wb;
        idx = (int'(acc.word_address) >> wb) & ((1 << ib) - 1);
        tag = TAG_W'(int'(acc.word_address) >> (wb + ib));
        hit = line_valid[idx] && (line_tag[idx] == tag);
        is_write = (acc.action == ACT_WRITE);

        tallies.hit        = hit;
        tallies.wrote_back = 1'b0;
        if (is_write) tallies.cpu_writes = sat_add(tallies.cpu_writes, 1);
        else tallies.cpu_reads = sat_add(tallies.cpu_reads, 1);

        if (hit) begin
            if (is_write) begin
                tallies.write_hits = sat_add(tallies.write_hits, 1);
                line_dirty[idx] = 1'b1;
            end else begin
                tallies.read_hits = sat_add(tallies.read_hits, 1);
            end
        end else begin
            // Write-allocate: the victim goes back only if it was modified.
            if (line_valid[idx] && line_dirty[idx]) begin
                tallies.wrote_back = 1'b1;
                tallies.mem_words_written = sat_add(tallies.mem_words_written, block_words);
            end
            tallies.mem_words_read = sat_add(tallies.mem_words_read, block_words);
            line_valid[idx] = 1'b1;
            line_tag[idx]   = tag;
            line_dirty[idx] = is_write;
            if (is_write) tallies.write_misses = sat_add(tallies.write_misses, 1);
            else tallies.read_misses = sat_add(tallies.read_misses, 1);
        end
        res = tallies;
    endtask

    task automatic compare_field(input string field, input logic [CNT_W-1:0] want,
                                 input logic [CNT_W-1:0] got);
        if (want !== got) begin
            if (mismatches < PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp predicted;
        t_rsp oldest;
        if (!i_rst_n) begin
            blocks_log2_q = RST_BLOCKS_LOG2;
            words_log2_q  = RST_WORDS_LOG2;
            for (int i = 0; i < DEF_MAX_LINES; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_tag[i]   = '0;
            end
            tallies = '0;
            outcomes_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_beat.index)
                    REG_BLOCKS_LOG2: blocks_log2_q = i_cfg_beat.data[3:0];
                    REG_WORDS_LOG2:  words_log2_q  = i_cfg_beat.data[2:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                predict_access(i_req_beat, predicted);
                outcomes_due.push_back(predicted);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (outcomes_due.size() == 0) begin
                    if (mismatches < PRINT_LIMIT)
                        $display({"%0t: result beat with no access outstanding, ",
                                  "expected none, got hit %0b wrote_back %0b"},
                                 $time, i_rsp_beat.hit, i_rsp_beat.wrote_back);
                    mismatches++;
                end else begin
                    oldest = outcomes_due.pop_front();
                    compare_field("hit", CNT_W'(oldest.hit), CNT_W'(i_rsp_beat.hit));
                    compare_field("wrote_back", CNT_W'(oldest.wrote_back),
                                  CNT_W'(i_rsp_beat.wrote_back));
                    compare_field("cpu_reads", oldest.cpu_reads, i_rsp_beat.cpu_reads);
                    compare_field("cpu_writes", oldest.cpu_writes, i_rsp_beat.cpu_writes);
                    compare_field("mem_words_read", oldest.mem_words_read,
                                  i_rsp_beat.mem_words_read);
                    compare_field("mem_words_written", oldest.mem_words_written,
                                  i_rsp_beat.mem_words_written);
                    compare_field("read_hits", oldest.read_hits, i_rsp_beat.read_hits);
                    compare_field("read_misses", oldest.read_misses, i_rsp_beat.read_misses);
                    compare_field("write_hits", oldest.write_hits, i_rsp_beat.write_hits);
                    compare_field("write_misses", oldest.write_misses,
                                  i_rsp_beat.write_misses);
                end
            end
        end
        due_count = outcomes_due.size();
    end

endmodule

// ===== tb/direct_mapped_writeback_cache_tags_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag unit testbench
// Drives CPU accesses and split register writes into the cache tag unit and
// lets the checker judge every result beat. A directed run of hits, misses,
// clean and dirty evictions comes first, then phases of random accesses with
// address locality under a range of block and word splits, including
// out-of-range register values. Both channels idle at random, and once the
// result side holds off long enough for the unit to back up.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_tags_unit_tb;
    import dmwbc_pkg::*;

    localparam int     CLK_HALF_NS        = 10;
    localparam int     RESET_CYCLES       = 7;
    localparam int     N_PHASES           = 10;
    localparam int     ACCESSES_PER_PHASE = 195;
    localparam int     HOLD_PHASE         = 3;
    localparam int     HOLD_AT            = 30;
    localparam int     HOLD_BURST         = 60;
    localparam int     LONG_HOLD_CYCLES   = 200;
    localparam int     SETTLE_CYCLES      = 16;
    localparam int     LINE_BITS          = $clog2(DEF_MAX_LINES);
    localparam longint TIMEOUT_NS         = 64'd20_000_000;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    bit                   steady_flow  = 1'b0;
    bit                   hold_rsp_req = 1'b0;
    int                   fail_count;
    int                   outstanding;
    int                   tag_shift   = 10;
    int                   offset_bits = 2;
    logic [ADDR_BITS-1:0] recent_addr [8];

    dmwbc_chan_if #(.t_payload(t_cfg_beat)) cfg_ch ();
    dmwbc_chan_if #(.t_payload(t_req))      req_ch ();
    dmwbc_chan_if #(.t_payload(t_rsp))      rsp_ch ();

    direct_mapped_writeback_cache_tags_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    direct_mapped_writeback_cache_tags_unit_checker u_access_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_ch.valid),
        .i_cfg_ready   (cfg_ch.ready),
        .i_cfg_beat    (cfg_ch.payload),
        .i_req_valid   (req_ch.valid),
        .i_req_ready   (req_ch.ready),
        .i_req_beat    (req_ch.payload),
        .i_rsp_valid   (rsp_ch.valid),
        .i_rsp_ready   (rsp_ch.ready),
        .i_rsp_beat    (rsp_ch.payload),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // Mostly short idle stretches, a few long ones, none while flow is steady.
    function automatic int pick_idle();
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Most addresses revisit a recent block or collide with it on the same
    // line, so that hits and dirty evictions are common; the rest are noise.
    function automatic logic [ADDR_BITS-1:0] next_address();
        logic [ADDR_BITS-1:0] base;
        int                   roll;
        base = recent_addr[$urandom_range(0, 7)];
        roll = $urandom_range(0, 99);
        if (roll < 45) return base ^ (ADDR_BITS'($urandom) & ADDR_BITS'((1 << offset_bits) - 1));
        if (roll < 75) return base ^ (ADDR_BITS'($urandom_range(1, 7)) << tag_shift);
        return ADDR_BITS'($urandom);
    endfunction

    task automatic offer_access(input t_req acc, input int idle);
        @(negedge i_clk);
        if (idle > 0) begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= t_req'($urandom);
            repeat (idle) @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= acc;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= '{index: idx, data: val};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_split(input logic [CFG_DATA_W-1:0] blocks_val,
                               input logic [CFG_DATA_W-1:0] words_val);
        int ib;
        int wb;
        write_reg(REG_BLOCKS_LOG2, blocks_val);
        write_reg(REG_WORDS_LOG2, words_val);
        ib = int'(blocks_val[3:0]);
        if (ib < 1) ib = 1;
        else if (ib > LINE_BITS) ib = LINE_BITS;
        wb = int'(words_val[2:0]);
        if (wb < 1) wb = 1;
        else if (wb > WORD_BITS) wb = WORD_BITS;
        offset_bits = wb;
        tag_shift   = ib + wb;
    endtask

    // Result side: random stalls, and one long hold-off on request.
    initial begin
        int idle;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp_req) begin
                hold_rsp_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                idle = pick_idle();
                if (idle == 0) begin
                    rsp_ch.ready <= 1'b1;
                end else begin
                    rsp_ch.ready <= 1'b0;
                    repeat (idle - 1) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        t_req                 acc;
        int                   n;
        logic [ADDR_BITS-1:0] addr_cur;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        foreach (recent_addr[i]) recent_addr[i] = ADDR_BITS'($urandom);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed run at the reset split: index is address bits 9:2, tag 15:10.
        apply_split(CFG_DATA_W'(RST_BLOCKS_LOG2), CFG_DATA_W'(RST_WORDS_LOG2));
        offer_access('{ACT_READ,  16'h0000}, 0);  // cold miss
        offer_access('{ACT_READ,  16'h0003}, 0);  // hit at the last offset
        offer_access('{ACT_WRITE, 16'h0001}, 0);  // write hit makes the line dirty
        offer_access('{ACT_READ,  16'h0400}, 0);  // conflict, dirty victim goes back
        offer_access('{ACT_WRITE, 16'h8000}, 0);  // write miss over a clean line
        offer_access('{ACT_WRITE, 16'h0000}, 0);  // write miss over a dirty line
        offer_access('{ACT_WRITE, 16'hFFFF}, 0);  // top address, last line
        offer_access('{ACT_READ,  16'hFFFC}, 0);
        offer_access('{ACT_READ,  16'h03FF}, 0);
        offer_access('{ACT_READ,  16'h7FFF}, 0);
        // Two runs of back-to-back beats, each on one line, check that each update
        // is seen by the next lookup.
        offer_access('{ACT_WRITE, 16'h1234}, 0);
        offer_access('{ACT_READ,  16'h1235}, 0);
        offer_access('{ACT_WRITE, 16'h5234}, 0);
        offer_access('{ACT_READ,  16'h1236}, 0);
        offer_access('{ACT_READ,  16'h2000}, 0);
        offer_access('{ACT_READ,  16'h6000}, 0);
        offer_access('{ACT_WRITE, 16'h6001}, 0);
        offer_access('{ACT_READ,  16'h2002}, 0);

        for (int phase = 0; phase <= N_PHASES; phase++) begin
            // Registers change only once every result is back; lines survive it.
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            do @(negedge i_clk); while (outstanding != 0);
            if (phase == N_PHASES) break;

            case (phase)
                0: apply_split(8'd1, 8'd1);
                1: apply_split(8'd8, 8'd5);
                2: apply_split(8'd0, 8'd0);
                3: apply_split(8'd15, 8'd7);
                4: apply_split(8'hF3, 8'h5B);
                5: apply_split(8'h29, 8'hAC);
                default: apply_split(CFG_DATA_W'($urandom_range(1, LINE_BITS)),
                                     CFG_DATA_W'($urandom_range(1, WORD_BITS)));
            endcase

            for (n = 0; n < ACCESSES_PER_PHASE; n++) begin
                if ($urandom_range(0, 49) == 0) steady_flow = ~steady_flow;
                addr_cur = next_address();
                recent_addr[$urandom_range(0, 7)] = addr_cur;
                acc.action       = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
                acc.word_address = addr_cur;
                if (phase == HOLD_PHASE && n == HOLD_AT) hold_rsp_req = 1'b1;
                // Keep offering beats flat out while the result side is held.
                if (phase == HOLD_PHASE && n >= HOLD_AT && n < HOLD_AT + HOLD_BURST)
                    offer_access(acc, 0);
                else
                    offer_access(acc, pick_idle());
            end
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dmwbc_pkg.sv
rtl/core/dmwbc_chan_if.sv
rtl/core/direct_mapped_writeback_cache_tags_unit.sv
tb/direct_mapped_writeback_cache_tags_unit_checker.sv
tb/direct_mapped_writeback_cache_tags_unit_tb.sv
